// ----- design/dotted_name_label_prefixer_macros.svh -----
// Assertion macros used by the dotted name label prefixer back end.
`ifndef DOTTED_NAME_LABEL_PREFIXER_MACROS_SVH
`define DOTTED_NAME_LABEL_PREFIXER_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define DNLP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("dnlp assertion failed");
// Condition that must never be true at a clock edge out of reset.
`define DNLP_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("dnlp forbidden condition seen");
`else
`define DNLP_ASSERT(name, clk, rstn, prop)
`define DNLP_NEVER(name, clk, rstn, cond)
`endif

`endif

// ----- design/dnlp_pkg.sv -----
// Types and constants shared by the dotted name label prefixer modules.
package dnlp_pkg;

  // Delimiter codes of the input character stream.
  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] END_CHAR = 8'd0;

  // Reset value of the length offset register (ASCII zero).
  localparam logic [7:0] OFFSET_RESET = 8'd48;

  // Default label buffer size and the width of a label length.
  localparam int MAX_LABEL_DEFAULT = 32;
  localparam int LEN_W = 6;

  // Number of label banks and of queued label commands.
  localparam int CMD_DEPTH = 2;

  // A finished label handed from the front to the back.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             is_end;
  } cmd_t;

  // A label character written into the label buffer.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

endpackage

// ----- design/dnlp_if.sv -----
// Stream and configuration channel interfaces of the dotted name label prefixer.

// Input character channel.
interface dnlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// Output byte channel.
interface dnlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_prefix;
  logic       label_overflow;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_prefix,
                  output label_overflow, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input is_prefix,
                input label_overflow, input last_of_run, output ready);
endinterface

// Length offset register write channel.
interface dnlp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] length_offset;

  modport source (output valid, output length_offset, input ready);
  modport sink (input valid, input length_offset, output ready);
endinterface

// ----- design/dnlp_front.sv -----
// Front end: accepts characters, fills the current label bank, queues finished labels.
module dnlp_front #(
  parameter int MAX_LABEL = dnlp_pkg::MAX_LABEL_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dnlp_char_if.sink         in_ch,
  input  logic              fifo_full_i,
  output logic              push_o,
  output dnlp_pkg::cmd_t    cmd_o,
  output dnlp_pkg::wr_t     wr_o
);

  localparam logic [dnlp_pkg::LEN_W-1:0] MaxLen = dnlp_pkg::LEN_W'(MAX_LABEL);

  logic [dnlp_pkg::LEN_W-1:0] len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic                       bank_q, bank_d;
  logic                       accept;
  logic                       is_delim;
  logic                       has_room;

  // A character transfer needs a free queue slot, which also means a free bank.
  assign in_ch.ready = !fifo_full_i;
  assign accept      = in_ch.valid && !fifo_full_i;
  assign has_room    = (len_q < MaxLen);

  always_comb begin
    is_delim = in_ch.char_in inside {dnlp_pkg::DOT_CHAR, dnlp_pkg::END_CHAR};
  end

  // Buffer write of an ordinary character while the label has room.
  always_comb begin
    wr_o.en   = accept && !is_delim && has_room;
    wr_o.bank = bank_q;
    wr_o.idx  = len_q;
    wr_o.data = in_ch.char_in;
  end

  // A delimiter closes the label and hands it to the back end.
  always_comb begin
    push_o       = accept && is_delim;
    cmd_o.bank   = bank_q;
    cmd_o.len    = len_q;
    cmd_o.ovf    = ovf_q;
    cmd_o.is_end = (in_ch.char_in == dnlp_pkg::END_CHAR);
  end

  // Label length, truncation flag and bank selection.
  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    bank_d = bank_q;
    if (accept) begin
      if (is_delim) begin
        len_d  = '0;
        ovf_d  = 1'b0;
        bank_d = !bank_q;
      end else if (has_room) begin
        len_d = len_q + dnlp_pkg::LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

endmodule

// ----- design/dnlp_cmd_fifo.sv -----
// Short queue of finished label commands between the front and back ends.
module dnlp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dnlp_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output dnlp_pkg::cmd_t cmd_o,
  output logic           valid_o,
  output logic           full_o
);

  localparam int Depth = dnlp_pkg::CMD_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dnlp_pkg::cmd_t      entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign cmd_o   = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  // Entry storage; an entry stays until the back end has drained its label.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- design/dnlp_back.sv -----
// Back end: label buffer memory and the sequencer that emits prefix, label bytes and terminator.
`include "dotted_name_label_prefixer_macros.svh"

module dnlp_back #(
  parameter int MAX_LABEL = dnlp_pkg::MAX_LABEL_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dnlp_pkg::wr_t  wr_i,
  input  dnlp_pkg::cmd_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  dnlp_cfg_if.sink       cfg_ch,
  dnlp_byte_if.source    out_ch
);

  localparam int AddrW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int LenW  = dnlp_pkg::LEN_W;

  typedef enum logic [1:0] {
    ST_PREFIX,
    ST_BYTES,
    ST_TERM
  } state_e;

  state_e          state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] rd_idx;
  logic [AddrW:0]  rd_addr;
  logic [7:0]      rd_data_q;
  logic [7:0]      offset_q;
  logic            can_load;
  logic            last_idx;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       is_prefix_q, is_prefix_d;
  logic       ovf_q, ovf_d;
  logic       last_q, last_d;

  // Two label banks, each one label deep.
  logic [7:0] mem_q [2 << AddrW];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.idx[AddrW-1:0]}] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // The output register can take a new result when empty or when drained now.
  assign can_load = !out_valid_q || out_ch.ready;
  assign last_idx = (idx_q == head_i.len - LenW'(1));
  assign cfg_ch.ready = 1'b1;

  // Read one byte ahead; hold the address while the output stalls.
  always_comb begin
    if (state_q == ST_BYTES) begin
      rd_idx = can_load ? idx_q + LenW'(1) : idx_q;
    end else begin
      rd_idx = '0;
    end
    rd_addr = {head_i.bank, rd_idx[AddrW-1:0]};
  end

  // Sequencer over the label at the head of the queue.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_byte_d  = out_byte_q;
    is_prefix_d = is_prefix_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    case (state_q)
      ST_PREFIX: begin
        if (head_valid_i && can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'(head_i.len) + offset_q;
          is_prefix_d = 1'b1;
          ovf_d       = head_i.ovf;
          last_d      = (head_i.len == '0) && !head_i.is_end;
          idx_d       = '0;
          if (head_i.len != '0) begin
            state_d = ST_BYTES;
          end else if (head_i.is_end) begin
            state_d = ST_TERM;
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      ST_BYTES: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_data_q;
          is_prefix_d = 1'b0;
          ovf_d       = 1'b0;
          last_d      = last_idx && !head_i.is_end;
          idx_d       = idx_q + LenW'(1);
          if (last_idx) begin
            if (head_i.is_end) begin
              state_d = ST_TERM;
            end else begin
              pop_o   = 1'b1;
              state_d = ST_PREFIX;
            end
          end
        end
      end
      ST_TERM: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = dnlp_pkg::END_CHAR;
          is_prefix_d = 1'b0;
          ovf_d       = 1'b0;
          last_d      = 1'b1;
          pop_o       = 1'b1;
          state_d     = ST_PREFIX;
        end
      end
      default: begin
        state_d = ST_PREFIX;
      end
    endcase
  end

  // State, offset register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PREFIX;
      idx_q       <= '0;
      offset_q    <= dnlp_pkg::OFFSET_RESET;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      is_prefix_q <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      is_prefix_q <= is_prefix_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      if (cfg_ch.valid) begin
        offset_q <= cfg_ch.length_offset;
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.out_byte       = out_byte_q;
  assign out_ch.is_prefix      = is_prefix_q;
  assign out_ch.label_overflow = ovf_q;
  assign out_ch.last_of_run    = last_q;

  // A label is being drained only while its command sits at the queue head.
  `DNLP_ASSERT(a_busy_has_head, clk_i, rst_ni, (state_q != ST_PREFIX) |-> head_valid_i)
  // The byte index never runs past the queued label length.
  `DNLP_ASSERT(a_idx_in_label, clk_i, rst_ni, (state_q == ST_BYTES) |-> (idx_q < head_i.len))
  // A stalled output freezes the sequencer position.
  `DNLP_ASSERT(a_stall_holds_idx, clk_i, rst_ni, (out_valid_q && !out_ch.ready) |=> $stable(idx_q))
  // A command is retired only when one is present.
  `DNLP_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_o && !head_valid_i)

endmodule

// ----- design/dotted_name_label_prefixer.sv -----
// Top level of the dotted name label prefixer.
//
// Characters arrive one per transfer; an ordinary character is written into the current
// label bank, a dot or a zero byte closes the label and queues it. The back end then emits
// one result per cycle while the receiver takes them: the length prefix, the label bytes
// and, at the end of a name, the zero terminator. The label buffer has two banks and the
// command queue two entries, so the front keeps taking the next label while the back
// drains the previous one; the front stalls only when both banks wait to be drained.
// Sustained throughput is one result per cycle from the output register, so with a
// receiver that never stalls the block takes about one input character per cycle, since
// each stored character leaves once and each label adds only its prefix (and a name its
// terminator). The buffer needs no clearing after reset.
module dotted_name_label_prefixer #(
  parameter int MAX_LABEL = dnlp_pkg::MAX_LABEL_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dnlp_char_if.sink   in_ch,
  dnlp_byte_if.source out_ch,
  dnlp_cfg_if.sink    cfg_ch
);

  logic           push;
  logic           pop;
  logic           fifo_full;
  logic           head_valid;
  dnlp_pkg::cmd_t push_cmd;
  dnlp_pkg::cmd_t head_cmd;
  dnlp_pkg::wr_t  buf_wr;

  // Character intake and label bookkeeping.
  dnlp_front #(
    .MAX_LABEL (MAX_LABEL)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .wr_o        (buf_wr)
  );

  // Queue of finished labels.
  dnlp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .valid_o (head_valid),
    .full_o  (fifo_full)
  );

  // Label buffer and output sequencer.
  dnlp_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (buf_wr),
    .head_i       (head_cmd),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch)
  );

endmodule
